// ===== design/erq_pkg.sv =====
// ----------------------------------------------------------------------------
// erq_pkg
// shared types, codes and defaults of the event ready queue engine
// ----------------------------------------------------------------------------
package erq_pkg;

  localparam int SOCKETS_DEFAULT    = 64;
  localparam int RING_DEPTH_DEFAULT = 64;

  localparam int EV_W    = 7;
  localparam int SID_W   = 6;
  localparam int TAG_W   = 64;
  localparam int LIMIT_W = 7;
  localparam int STAT_W  = 3;

  localparam logic [EV_W-1:0] EV_IN     = 7'h01;
  localparam logic [EV_W-1:0] EV_OUT    = 7'h04;
  localparam logic [EV_W-1:0] EV_FORCED = 7'h18;

  localparam logic [LIMIT_W-1:0] MAX_OUT = 7'd64;

  localparam logic [1:0] RING_NET    = 2'd0;
  localparam logic [1:0] RING_USER   = 2'd1;
  localparam logic [1:0] RING_SHADOW = 2'd2;
  localparam logic [1:0] RING_BAD    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ARG  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXISTS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_REG  = 3'd4;
  localparam logic [STAT_W-1:0] ST_NO_READY = 3'd5;

  typedef enum logic [2:0] {
    MODE_POST     = 3'd0,
    MODE_REGISTER = 3'd1,
    MODE_MODIFY   = 3'd2,
    MODE_REMOVE   = 3'd3,
    MODE_FLUSH    = 3'd4,
    MODE_HARVEST  = 3'd5,
    MODE_SET_OPEN = 3'd6,
    MODE_RSVD     = 3'd7
  } mode_t;

  // socket table word
  typedef struct packed {
    logic             open;
    logic [TAG_W-1:0] tag;
    logic [EV_W-1:0]  pend;
    logic [EV_W-1:0]  intr;
  } sock_t;

  // ring word
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SID_W-1:0] sid;
    logic [EV_W-1:0]  bits;
  } ring_t;

endpackage

// ===== design/erq_ram.sv =====
// ----------------------------------------------------------------------------
// erq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module erq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/event_ready_queue_engine.sv =====
// ----------------------------------------------------------------------------
// event_ready_queue_engine
// readiness event engine: socket table plus network, user and shadow rings
// ----------------------------------------------------------------------------
// One operation is taken at a time. Post, register, modify, remove and set
// open go through accept with socket table read, update and result; a
// register or modify that raises OUT on the shadow ring adds a ring write,
// and a reserved mode or an out of range socket id skips the update. Flush
// moves each entry with a ring read then a ring write. Harvest consumes each
// ring entry through a ring read, socket table read, pending write-back and
// delivery, bound by the single read port of each ram. A full output register
// holds the engine.
// Socket table entries read as zero until first written; the rings need no
// clearing since only counted entries are ever read.
module event_ready_queue_engine
  import erq_pkg::*;
#(
  parameter int SOCKETS    = SOCKETS_DEFAULT,
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode, queue_sel, socket_id, event_bits, user_data, max_count,
  // is_stream, established, rx_pending, tx_space, open_flag
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, ready_bits, ready_data
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int SW  = $clog2(SOCKETS);
  localparam int PW  = $clog2(RING_DEPTH);
  localparam int CW  = $clog2(RING_DEPTH + 1);
  localparam int RAW = $clog2(3 * RING_DEPTH);
  localparam int SOCK_BITS = $bits(sock_t);
  localparam int RING_BITS = $bits(ring_t);

  localparam logic [RAW-1:0] BASE1    = RAW'(RING_DEPTH);
  localparam logic [RAW-1:0] BASE2    = RAW'(2 * RING_DEPTH);
  localparam logic [CW-1:0]  CNT_FULL = CW'(RING_DEPTH);
  localparam logic [PW-1:0]  PTR_LAST = PW'(RING_DEPTH - 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_OP     = 10'b0000000010,
    S_RAISE  = 10'b0000000100,
    S_FL_RD  = 10'b0000001000,
    S_FL_WR  = 10'b0000010000,
    S_H_SEL  = 10'b0000100000,
    S_H_RING = 10'b0001000000,
    S_H_SOCK = 10'b0010000000,
    S_H_PUSH = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // latched operation
  mode_t            in_mode;
  logic [1:0]       in_q;
  logic [SID_W-1:0] in_sid;
  logic [EV_W-1:0]  in_bits;
  logic [TAG_W-1:0] in_data;
  logic             in_stream, in_est, in_rx, in_tx, in_open;
  logic [STAT_W-1:0] st;

  // harvest
  logic [1:0]         h_q;
  logic [LIMIT_W-1:0] h_cnt, h_limit;
  ring_t              ent;
  logic               deliver;
  logic               held_valid;
  logic [EV_W-1:0]    held_bits;
  logic [TAG_W-1:0]   held_data;

  // rings
  logic [PW-1:0] ring_head [3];
  logic [PW-1:0] ring_tail [3];
  logic [CW-1:0] ring_count [3];

  // socket table
  logic [SOCKETS-1:0] sock_valid;
  logic               sock_rd_valid;
  logic [SW-1:0]      sock_raddr, sock_waddr;
  logic               sock_we;
  sock_t              sock_rdata, sock_wdata, sv;

  logic               ring_we;
  logic [RAW-1:0]     ring_raddr, ring_waddr;
  ring_t              ring_rdata, ring_wdata;

  logic       push_en, pop_en;
  logic [1:0] push_q, pop_q;

  // output register
  logic              out_valid, out_last;
  logic [STAT_W-1:0] out_status;
  logic [EV_W-1:0]   out_bits;
  logic [TAG_W-1:0]  out_data;
  logic              out_free;
  logic              emit, emit_last;
  logic [STAT_W-1:0] emit_status;
  logic [EV_W-1:0]   emit_bits;
  logic [TAG_W-1:0]  emit_data;

  logic [SW-1:0]   in_idx, ent_idx;
  logic            accept;
  logic [CW-1:0]   cnt_q, cnt2;
  logic [PW-1:0]   tail_q, head_sel;
  logic            full_q, full2, full2b;
  logic            pend_hit, registered;
  logic [EV_W-1:0] intr_new, pend1;
  logic            raise_ok, post_in, post_out, h_deliver;
  logic [1:0]      sel_q;
  logic [RAW-1:0]  base_q, base_sel;
  logic [LIMIT_W-1:0] max_in;

  function automatic logic [RAW-1:0] ring_base(input logic [1:0] q);
    logic [RAW-1:0] b;
    case (q)
      RING_USER:   b = BASE1;
      RING_SHADOW: b = BASE2;
      default:     b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  erq_ram #(.WIDTH(SOCK_BITS), .DEPTH(SOCKETS)) u_sock_ram (
    .clk   (clk),
    .we    (sock_we),
    .waddr (sock_waddr),
    .wdata (sock_wdata),
    .raddr (sock_raddr),
    .rdata (sock_rdata)
  );

  erq_ram #(.WIDTH(RING_BITS), .DEPTH(3 * RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {6'b0, out_data, out_bits, out_status};

  assign in_idx  = SW'(in_sid);
  assign ent_idx = SW'(ent.sid);
  assign sv      = sock_rd_valid ? sock_rdata : '0;
  assign max_in  = s_axis_tdata[88:82];

  always_comb begin
    case (in_q)
      RING_USER:   begin cnt_q = ring_count[1]; tail_q = ring_tail[1]; end
      RING_SHADOW: begin cnt_q = ring_count[2]; tail_q = ring_tail[2]; end
      default:     begin cnt_q = ring_count[0]; tail_q = ring_tail[0]; end
    endcase
  end

  assign base_q   = ring_base(in_q);
  assign full_q   = (cnt_q == CNT_FULL);
  assign cnt2     = ring_count[2];
  assign full2    = (cnt2 == CNT_FULL);
  assign pend_hit = |(sv.pend & in_bits);
  assign registered = |sv.intr;
  assign intr_new = in_bits | EV_FORCED;
  assign raise_ok = in_stream && in_est;
  assign post_in  = raise_ok && intr_new[0] && in_rx && !sv.pend[0] && !full2;
  assign pend1    = sv.pend | (post_in ? EV_IN : '0);
  assign full2b   = post_in ? (cnt2 + 1'b1 == CNT_FULL) : full2;
  assign post_out = raise_ok && intr_new[2] && in_tx && !pend1[2] && !full2b;

  assign sel_q    = (ring_count[1] != '0) ? RING_USER : RING_SHADOW;
  assign base_sel = ring_base(sel_q);
  assign head_sel = (sel_q == RING_USER) ? ring_head[1] : ring_head[2];
  assign h_deliver = sv.open && |(sv.intr & ent.bits) && |(sv.pend & ent.bits);

  always_comb begin
    state_next  = state;
    sock_we     = 1'b0;
    sock_waddr  = in_idx;
    sock_wdata  = sv;
    sock_raddr  = SW'(s_axis_tdata[10:5]);
    ring_we     = 1'b0;
    ring_waddr  = base_q + RAW'(tail_q);
    ring_wdata  = '{tag: sv.tag, sid: in_sid, bits: in_bits};
    ring_raddr  = RAW'(ring_head[0]);
    push_en     = 1'b0;
    push_q      = in_q;
    pop_en      = 1'b0;
    pop_q       = h_q;
    emit        = 1'b0;
    emit_status = st;
    emit_bits   = '0;
    emit_data   = '0;
    emit_last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode_t'(s_axis_tdata[2:0]) == MODE_HARVEST) begin
            state_next = (max_in == '0) ? S_DONE : S_H_SEL;
          end else if (mode_t'(s_axis_tdata[2:0]) == MODE_FLUSH) begin
            state_next = S_FL_RD;
          end else if (mode_t'(s_axis_tdata[2:0]) == MODE_RSVD ||
                       32'(s_axis_tdata[10:5]) >= SOCKETS) begin
            state_next = S_DONE;
          end else begin
            state_next = S_OP;
          end
        end
      end

      S_OP: begin
        state_next = S_DONE;
        case (in_mode)
          MODE_POST: begin
            if (in_bits != '0 && !pend_hit && in_q != RING_BAD && !full_q) begin
              sock_we         = 1'b1;
              sock_wdata.pend = sv.pend | in_bits;
              ring_we         = 1'b1;
              push_en         = 1'b1;
            end
          end
          MODE_REGISTER, MODE_MODIFY: begin
            if ((in_mode == MODE_REGISTER) == !registered) begin
              sock_we         = 1'b1;
              sock_wdata.intr = intr_new;
              sock_wdata.tag  = in_data;
              sock_wdata.pend = pend1 | (post_out ? EV_OUT : '0);
              ring_waddr      = BASE2 + RAW'(ring_tail[2]);
              ring_wdata      = '{tag: in_data, sid: in_sid, bits: EV_IN};
              ring_we         = post_in;
              push_en         = post_in;
              push_q          = RING_SHADOW;
              if (post_out) begin
                state_next = S_RAISE;
              end
            end
          end
          MODE_REMOVE: begin
            if (registered) begin
              sock_we         = 1'b1;
              sock_wdata.intr = '0;
            end
          end
          default: begin
            sock_we         = 1'b1;
            sock_wdata.open = in_open;
          end
        endcase
      end

      S_RAISE: begin
        ring_we    = 1'b1;
        ring_waddr = BASE2 + RAW'(ring_tail[2]);
        ring_wdata = '{tag: in_data, sid: in_sid, bits: EV_OUT};
        push_en    = 1'b1;
        push_q     = RING_SHADOW;
        state_next = S_DONE;
      end

      S_FL_RD: begin
        ring_raddr = RAW'(ring_head[0]);
        if (ring_count[0] != '0 && ring_count[1] != CNT_FULL) begin
          state_next = S_FL_WR;
        end else begin
          state_next = S_DONE;
        end
      end

      S_FL_WR: begin
        ring_we    = 1'b1;
        ring_waddr = BASE1 + RAW'(ring_tail[1]);
        ring_wdata = ring_rdata;
        push_en    = 1'b1;
        push_q     = RING_USER;
        pop_en     = 1'b1;
        pop_q      = RING_NET;
        state_next = S_FL_RD;
      end

      S_H_SEL: begin
        ring_raddr = base_sel + RAW'(head_sel);
        if (h_cnt != h_limit && (ring_count[1] != '0 || ring_count[2] != '0)) begin
          state_next = S_H_RING;
        end else begin
          state_next = S_DONE;
        end
      end

      S_H_RING: begin
        sock_raddr = SW'(ring_rdata.sid);
        state_next = S_H_SOCK;
      end

      S_H_SOCK: begin
        sock_we         = 1'b1;
        sock_waddr      = ent_idx;
        sock_wdata.pend = sv.pend & ~ent.bits;
        pop_en          = 1'b1;
        state_next      = S_H_PUSH;
      end

      S_H_PUSH: begin
        if (!deliver || !held_valid) begin
          state_next = S_H_SEL;
        end else if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_OK;
          emit_bits   = held_bits;
          emit_data   = held_data;
          emit_last   = 1'b0;
          state_next  = S_H_SEL;
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (held_valid) begin
            emit_status = ST_OK;
            emit_bits   = held_bits;
            emit_data   = held_data;
          end
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // ring pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ring_head[i]  <= '0;
        ring_tail[i]  <= '0;
        ring_count[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (push_en && push_q == 2'(i)) begin
          ring_tail[i] <= ptr_inc(ring_tail[i]);
        end
        if (pop_en && pop_q == 2'(i)) begin
          ring_head[i] <= ptr_inc(ring_head[i]);
        end
        if ((push_en && push_q == 2'(i)) && !(pop_en && pop_q == 2'(i))) begin
          ring_count[i] <= ring_count[i] + 1'b1;
        end else if (!(push_en && push_q == 2'(i)) && (pop_en && pop_q == 2'(i))) begin
          ring_count[i] <= ring_count[i] - 1'b1;
        end
      end
    end
  end

  // socket table valid bits, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      sock_valid    <= '0;
      sock_rd_valid <= 1'b0;
    end else begin
      sock_rd_valid <= sock_valid[sock_raddr];
      if (sock_we) begin
        sock_valid[sock_waddr] <= 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == S_H_PUSH && deliver && (!held_valid || out_free)) begin
        held_valid <= 1'b1;
      end else if (state == S_DONE && out_free) begin
        held_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= emit_status;
      out_bits   <= emit_bits;
      out_data   <= emit_data;
      out_last   <= emit_last;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          in_mode   <= mode_t'(s_axis_tdata[2:0]);
          in_q      <= s_axis_tdata[4:3];
          in_sid    <= s_axis_tdata[10:5];
          in_bits   <= s_axis_tdata[17:11];
          in_data   <= s_axis_tdata[81:18];
          in_stream <= s_axis_tdata[89];
          in_est    <= s_axis_tdata[90];
          in_rx     <= s_axis_tdata[91];
          in_tx     <= s_axis_tdata[92];
          in_open   <= s_axis_tdata[93];
          h_cnt     <= '0;
          h_limit   <= max_in[6] ? MAX_OUT : max_in;
          if (state_next == S_DONE) begin
            st <= ST_BAD_ARG;
          end else begin
            st <= ST_OK;
          end
        end
      end
      S_OP: begin
        case (in_mode)
          MODE_POST: begin
            if (in_bits == '0) begin
              st <= ST_BAD_ARG;
            end else if (pend_hit) begin
              st <= ST_OK;
            end else if (in_q == RING_BAD) begin
              st <= ST_BAD_ARG;
            end else if (full_q) begin
              st <= ST_FULL;
            end
          end
          MODE_REGISTER: begin
            if (registered) st <= ST_EXISTS;
          end
          MODE_MODIFY: begin
            if (!registered) st <= ST_NOT_REG;
          end
          MODE_REMOVE: begin
            if (!registered) st <= ST_NOT_REG;
          end
          default: begin
          end
        endcase
      end
      S_H_SEL: begin
        h_q <= sel_q;
        if (state_next == S_DONE && h_cnt == '0) begin
          st <= ST_NO_READY;
        end
      end
      S_H_RING: begin
        ent <= ring_rdata;
      end
      S_H_SOCK: begin
        deliver <= h_deliver;
      end
      S_H_PUSH: begin
        if (deliver && (!held_valid || out_free)) begin
          held_bits <= ent.bits;
          held_data <= ent.tag;
          h_cnt     <= h_cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== verif/event_ready_queue_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_ready_queue_engine_test
// drives posts, socket table operations, flushes and harvests into the engine,
// predicts every result from a behavioural copy of the tables and rings, and
// checks the result stream field by field under random idling on both sides
// ----------------------------------------------------------------------------
module event_ready_queue_engine_test;
  import erq_pkg::*;

  localparam int NSOCK     = 64;
  localparam int DEPTH     = 64;
  localparam int LIMIT_CYC = 1500000;

  typedef struct {
    mode_t             mode;
    logic [1:0]        ring;
    logic [SID_W-1:0]  sid;
    logic [EV_W-1:0]   ev;
    logic [TAG_W-1:0]  tag;
    logic [LIMIT_W-1:0] limit;
    logic              stream;
    logic              estab;
    logic              rx;
    logic              tx;
    logic              opn;
  } op_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [EV_W-1:0]   bits;
    logic [TAG_W-1:0]  data;
    logic              last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;

  // behavioural copy of the engine state
  logic [EV_W-1:0]  intr_mask [NSOCK];
  logic [EV_W-1:0]  pend_mask [NSOCK];
  logic [TAG_W-1:0] sock_tag  [NSOCK];
  logic             sock_open [NSOCK];
  logic [SID_W-1:0] ring_sid  [3][DEPTH];
  logic [EV_W-1:0]  ring_bits [3][DEPTH];
  logic [TAG_W-1:0] ring_tag  [3][DEPTH];
  int               ring_head [3];
  int               ring_tail [3];
  int               ring_cnt  [3];

  result_t expected_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      idling = 1'b1;

  event_ready_queue_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void push_result(logic [STAT_W-1:0] st, logic [EV_W-1:0] b,
                                      logic [TAG_W-1:0] d, logic l);
    result_t r;
    r.status = st;
    r.bits   = b;
    r.data   = d;
    r.last   = l;
    expected_results.push_back(r);
  endfunction

  function automatic logic [STAT_W-1:0] queue_event(logic [1:0] q, int sid,
                                                    logic [EV_W-1:0] b);
    if (b == '0) return ST_BAD_ARG;
    if ((pend_mask[sid] & b) != '0) return ST_OK;
    if (q == RING_BAD) return ST_BAD_ARG;
    if (ring_cnt[q] >= DEPTH) return ST_FULL;
    pend_mask[sid] |= b;
    ring_sid[q][ring_tail[q]]  = SID_W'(sid);
    ring_bits[q][ring_tail[q]] = b;
    ring_tag[q][ring_tail[q]]  = sock_tag[sid];
    ring_tail[q] = (ring_tail[q] + 1) % DEPTH;
    ring_cnt[q]++;
    return ST_OK;
  endfunction

  function automatic void drain_ring(int q, int lim, ref int delivered,
                                     ref result_t got[$]);
    int n;
    int sid;
    logic [EV_W-1:0] b;
    result_t r;
    n = ring_cnt[q];
    for (int i = 0; i < n && delivered < lim; i++) begin
      sid = ring_sid[q][ring_head[q]];
      b   = ring_bits[q][ring_head[q]];
      if (sock_open[sid] && (intr_mask[sid] & b) != '0 && (pend_mask[sid] & b) != '0) begin
        r.status = ST_OK;
        r.bits   = b;
        r.data   = ring_tag[q][ring_head[q]];
        r.last   = 1'b0;
        got.push_back(r);
        delivered++;
      end
      pend_mask[sid] &= ~b;
      ring_head[q] = (ring_head[q] + 1) % DEPTH;
      ring_cnt[q]--;
    end
  endfunction

  function automatic void predict_op(op_t op);
    logic [STAT_W-1:0] st;
    int sid;
    int lim;
    int delivered;
    result_t got[$];
    st  = ST_OK;
    sid = op.sid;
    if (op.mode == MODE_HARVEST) begin
      lim = op.limit;
      delivered = 0;
      if (lim == 0) begin
        push_result(ST_BAD_ARG, '0, '0, 1'b1);
        return;
      end
      if (lim > MAX_OUT) lim = MAX_OUT;
      drain_ring(RING_USER, lim, delivered, got);
      drain_ring(RING_SHADOW, lim, delivered, got);
      if (delivered == 0) begin
        push_result(ST_NO_READY, '0, '0, 1'b1);
        return;
      end
      got[got.size()-1].last = 1'b1;
      foreach (got[i]) expected_results.push_back(got[i]);
      return;
    end
    case (op.mode)
      MODE_FLUSH: begin
        while (ring_cnt[RING_NET] > 0 && ring_cnt[RING_USER] < DEPTH) begin
          ring_sid[RING_USER][ring_tail[RING_USER]]  = ring_sid[RING_NET][ring_head[RING_NET]];
          ring_bits[RING_USER][ring_tail[RING_USER]] = ring_bits[RING_NET][ring_head[RING_NET]];
          ring_tag[RING_USER][ring_tail[RING_USER]]  = ring_tag[RING_NET][ring_head[RING_NET]];
          ring_tail[RING_USER] = (ring_tail[RING_USER] + 1) % DEPTH;
          ring_cnt[RING_USER]++;
          ring_head[RING_NET] = (ring_head[RING_NET] + 1) % DEPTH;
          ring_cnt[RING_NET]--;
        end
      end
      MODE_RSVD: st = ST_BAD_ARG;
      MODE_POST: st = queue_event(op.ring, sid, op.ev);
      MODE_REGISTER, MODE_MODIFY: begin
        if (op.mode == MODE_REGISTER && intr_mask[sid] != '0) st = ST_EXISTS;
        else if (op.mode == MODE_MODIFY && intr_mask[sid] == '0) st = ST_NOT_REG;
        else begin
          intr_mask[sid] = op.ev | EV_FORCED;
          sock_tag[sid]  = op.tag;
          // readiness raise on established stream sockets, refusals dropped
          if (op.stream && op.estab) begin
            if ((intr_mask[sid] & EV_IN) != '0 && op.rx)
              void'(queue_event(RING_SHADOW, sid, EV_IN));
            if ((intr_mask[sid] & EV_OUT) != '0 && op.tx && (pend_mask[sid] & EV_OUT) == '0)
              void'(queue_event(RING_SHADOW, sid, EV_OUT));
          end
        end
      end
      MODE_REMOVE: begin
        if (intr_mask[sid] == '0) st = ST_NOT_REG;
        else intr_mask[sid] = '0;
      end
      default: sock_open[sid] = op.opn;
    endcase
    push_result(st, '0, '0, 1'b1);
  endfunction

  task automatic send_op(op_t op);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, op.opn, op.tx, op.rx, op.estab, op.stream, op.limit,
                      op.tag, op.ev, op.sid, op.ring, op.mode};
    do @(posedge clk); while (!s_axis_tready);
    predict_op(op);
  endtask

  function automatic op_t make_op(mode_t m, int sid, logic [EV_W-1:0] ev);
    op_t op;
    op.mode   = m;
    op.ring   = RING_NET;
    op.sid    = SID_W'(sid);
    op.ev     = ev;
    op.tag    = {$urandom, $urandom};
    op.limit  = MAX_OUT;
    op.stream = 1'b0;
    op.estab  = 1'b0;
    op.rx     = 1'b0;
    op.tx     = 1'b0;
    op.opn    = 1'b1;
    return op;
  endfunction

  // receiver stall bursts
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (idling) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: status %0d bits %h data %h last %b",
                   m_axis_tdata[2:0], m_axis_tdata[9:3], m_axis_tdata[73:10], m_axis_tlast);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[2:0] !== want.status || m_axis_tdata[9:3] !== want.bits ||
            m_axis_tdata[73:10] !== want.data || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d bits %h data %h last %b, got %0d %h %h %b",
                     want.status, want.bits, want.data, want.last, m_axis_tdata[2:0],
                     m_axis_tdata[9:3], m_axis_tdata[73:10], m_axis_tlast);
        end
      end
    end
  end

  task automatic test_control_ops();
    op_t op;
    send_op(make_op(MODE_POST, 3, 7'h00));          // zero event
    send_op(make_op(MODE_MODIFY, 3, 7'h01));        // modify unregistered
    send_op(make_op(MODE_REMOVE, 3, 7'h00));        // remove unregistered
    send_op(make_op(MODE_RSVD, 3, 7'h01));
    op = make_op(MODE_REGISTER, 3, 7'h05);          // register while closed
    op.stream = 1'b1; op.estab = 1'b1; op.rx = 1'b1; op.tx = 1'b1;
    op.tag = '1;
    send_op(op);
    send_op(make_op(MODE_REGISTER, 3, 7'h7F));      // already registered
    send_op(make_op(MODE_SET_OPEN, 3, 7'h00));
    op = make_op(MODE_POST, 3, 7'h01);               // already pending
    send_op(op);
    op = make_op(MODE_POST, 63, 7'h7F);
    op.ring = RING_BAD;
    send_op(op);
    op.ring = RING_USER; op.sid = 3; op.ev = 7'h02;
    send_op(op);
    op = make_op(MODE_HARVEST, 0, 7'h00);
    op.limit = 7'd0;
    send_op(op);
    op.limit = 7'd127;
    send_op(op);
    send_op(op);                                     // nothing ready
    op = make_op(MODE_MODIFY, 3, 7'h7F);
    op.tag = '0;
    send_op(op);
    send_op(make_op(MODE_REMOVE, 3, 7'h00));
    op = make_op(MODE_POST, 3, 7'h08);
    op.ring = RING_SHADOW;
    send_op(op);
    op = make_op(MODE_SET_OPEN, 3, 7'h00);
    op.opn = 1'b0;
    send_op(op);
    op = make_op(MODE_HARVEST, 0, 7'h00);
    op.limit = 7'd1;
    send_op(op);                                     // stale entry dropped
    send_op(make_op(MODE_FLUSH, 0, 7'h00));
  endtask

  task automatic test_ring_full();
    op_t op;
    for (int s = 0; s < NSOCK; s++) begin
      op = make_op(MODE_POST, s, 7'h40);
      send_op(op);
    end
    op = make_op(MODE_POST, 0, 7'h20);               // network ring full
    send_op(op);
    send_op(make_op(MODE_FLUSH, 0, 7'h00));
    for (int s = 0; s < 4; s++) begin
      send_op(make_op(MODE_REGISTER, s, 7'h7F));
      send_op(make_op(MODE_SET_OPEN, s, 7'h00));
    end
    op = make_op(MODE_HARVEST, 0, 7'h00);
    op.limit = 7'd64;
    send_op(op);
  endtask

  task automatic test_random(int n);
    op_t op;
    int  pick;
    for (int i = 0; i < n; i++) begin
      if (i == n - 10) idling = 1'b0;
      pick = $urandom_range(0, 99);
      op = make_op(MODE_POST, $urandom_range(0, 9), EV_W'($urandom_range(0, 127)));
      if ($urandom_range(0, 9) == 0) op.sid = SID_W'($urandom_range(0, 63));
      if ($urandom_range(0, 2) != 0) op.ev = 7'h1 << $urandom_range(0, 6);
      op.ring   = $urandom_range(0, 9) == 0 ? RING_BAD : 2'($urandom_range(0, 2));
      op.limit  = $urandom_range(0, 9) == 0 ? LIMIT_W'($urandom_range(0, 127)) :
                                              LIMIT_W'($urandom_range(1, 8));
      op.stream = $urandom_range(0, 3) != 0;
      op.estab  = $urandom_range(0, 3) != 0;
      op.rx     = 1'($urandom_range(0, 1));
      op.tx     = 1'($urandom_range(0, 1));
      op.opn    = $urandom_range(0, 3) != 0;
      if (pick < 30) op.mode = MODE_POST;
      else if (pick < 45) op.mode = MODE_REGISTER;
      else if (pick < 55) op.mode = MODE_MODIFY;
      else if (pick < 60) op.mode = MODE_REMOVE;
      else if (pick < 68) op.mode = MODE_FLUSH;
      else if (pick < 85) op.mode = MODE_HARVEST;
      else if (pick < 98) op.mode = MODE_SET_OPEN;
      else op.mode = MODE_RSVD;
      send_op(op);
    end
  endtask

  initial begin
    for (int s = 0; s < NSOCK; s++) begin
      intr_mask[s] = '0; pend_mask[s] = '0; sock_tag[s] = '0; sock_open[s] = 1'b0;
    end
    for (int q = 0; q < 3; q++) begin
      ring_head[q] = 0; ring_tail[q] = 0; ring_cnt[q] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_control_ops();
    test_ring_full();
    test_random(24);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/erq_pkg.sv
design/erq_ram.sv
design/event_ready_queue_engine.sv
verif/event_ready_queue_engine_test.sv
